FILE: hw/rtl/ole_pkg.sv
package ole_pkg;

    // List geometry.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the request and response transactions.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 32;
    localparam int COUNT_W  = 7;

    // Internal widths derived from the geometry.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read-back reduction: taps are ORed in groups, then the groups are ORed.
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 3'd0,
        K_READ   = 3'd1,
        K_REMOVE = 3'd2,
        K_INSERT = 3'd3,
        K_POP    = 3'd4,
        K_PEEK   = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_READ
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic             tap;     // target cell drives its word to the read-back tree
        logic [CMP_W-1:0] target;  // cell addressed by the operation
        logic [CMP_W-1:0] last;    // entry count before the operation
        t_word            word;    // word to load for append and insert
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_GRP,
        S_SUM,
        S_OUT
    } t_state;

endpackage

FILE: hw/rtl/ole_if.sv
// Request channel: one list operation per transaction.
interface ole_req_if;
    import ole_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// Response channel: one result per request.
interface ole_rsp_if;
    import ole_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    data;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);
endinterface

FILE: hw/rtl/ordered_list_engine_unit.sv
// Ordered list of up to 64 words held in a row of cells, one word per cell.
// A request transaction appends, reads at an index, removes at an index,
// inserts at an index, pops the last entry or peeks at it; each returns one
// response transaction with a status, the word read or removed (zero
// otherwise) and the entry count after the request. All cells shift at once,
// so the row itself never limits the rate; the cost per request is set by the
// read-back path, which ORs the addressed cell's word through a two-level
// registered tree. A request is taken only when the previous response has
// been delivered; the word passes the cell tap, group and response registers
// in turn before the response is valid, so a new request waits until the
// previous response is taken. Entries hold no reset value; only entries below
// the count are ever returned.
module ordered_list_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ole_req_if.sink   i_req,
    ole_rsp_if.source o_rsp
);
    import ole_pkg::*;

    t_cell_cmd cmd;
    t_word     words [CAPACITY];
    t_word     taps  [CAPACITY];
    t_word     sum;

    // Request decode, entry count and response handshake.
    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_sum   (sum),
        .o_cmd   (cmd)
    );

    // Row of cells; each sees its neighbors for shifting up and down.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word left;
        t_word right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = words[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner_r
            assign right = words[g+1];
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CMP_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left),
            .i_right (right),
            .o_word  (words[g]),
            .o_tap   (taps[g])
        );
    end

    // Read-back reduction of the cell taps.
    ole_or_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_taps  (taps),
        .o_sum   (sum)
    );

endmodule

FILE: hw/rtl/ole_cell.sv
module ole_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [ole_pkg::CMP_W-1:0] i_index,
    input  ole_pkg::t_cell_cmd      i_cmd,
    input  ole_pkg::t_word          i_left,
    input  ole_pkg::t_word          i_right,
    output ole_pkg::t_word          o_word,
    output ole_pkg::t_word          o_tap
);
    import ole_pkg::*;

    t_word r_word;
    t_word n_word;
    t_word r_tap;
    logic  hit;

    assign hit = (i_index == i_cmd.target);

    // Decide what this position holds after the operation.
    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            CELL_APPEND: begin
                if (hit) begin
                    n_word = i_cmd.word;
                end
            end
            CELL_REMOVE: begin
                // Entries from the target up to the second-to-last shift down.
                if ((i_index >= i_cmd.target) && ((i_index + 1'b1) < i_cmd.last)) begin
                    n_word = i_right;
                end
            end
            CELL_INSERT: begin
                // The target loads the new word; entries above it shift up.
                if (hit) begin
                    n_word = i_cmd.word;
                end else if ((i_index > i_cmd.target) && (i_index <= i_cmd.last)) begin
                    n_word = i_left;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Entry storage holds no reset value.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Read-back tap carries the old word of the addressed cell, zero elsewhere.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_cmd.tap && hit) begin
            r_tap <= r_word;
        end else begin
            r_tap <= '0;
        end
    end

    assign o_word = r_word;
    assign o_tap  = r_tap;

endmodule

FILE: hw/rtl/ole_or_tree.sv
module ole_or_tree (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ole_pkg::t_word i_taps [ole_pkg::CAPACITY],
    output ole_pkg::t_word o_sum
);
    import ole_pkg::*;

    t_word r_grp [NUM_GROUPS];
    t_word n_grp [NUM_GROUPS];

    // First level: OR each group of taps.
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int m = 0; m < GROUP_SIZE; m++) begin
                if (g * GROUP_SIZE + m < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP_SIZE + m];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_grp[g] <= '0;
            end
        end else begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // Second level: OR the registered groups.
    always_comb begin
        o_sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            o_sum = o_sum | r_grp[g];
        end
    end

endmodule

FILE: hw/rtl/ole_ctrl.sv
module ole_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ole_req_if.sink            i_req,
    ole_rsp_if.source          o_rsp,
    input  ole_pkg::t_word     i_sum,
    output ole_pkg::t_cell_cmd o_cmd
);
    import ole_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_cell_cmd          r_cmd;
    t_cell_cmd          n_cmd;
    t_status            r_status;
    t_status            n_status;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [OUT_W-1:0]   r_data;
    logic               accept;
    logic               full;
    logic [CMP_W-1:0]   pos;
    logic [CMP_W-1:0]   cnt;

    assign accept = i_req.valid && i_req.ready;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign pos    = CMP_W'(i_req.position);
    assign cnt    = CMP_W'(r_count);

    // Decode a request into a status, the new count and the row command.
    always_comb begin
        n_status        = ST_OK;
        n_count         = r_count;
        n_cmd.op        = CELL_NOP;
        n_cmd.tap       = 1'b0;
        n_cmd.target    = pos;
        n_cmd.last      = cnt;
        n_cmd.word      = DATA_WIDTH'(i_req.value);
        case (i_req.kind)
            K_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd.op     = CELL_APPEND;
                    n_cmd.target = cnt;
                    n_count      = r_count + 1'b1;
                end
            end
            K_READ: begin
                if (pos >= cnt) begin
                    n_status = ST_INDEX;
                end else begin
                    n_cmd.op  = CELL_READ;
                    n_cmd.tap = 1'b1;
                end
            end
            K_REMOVE: begin
                if (pos >= cnt) begin
                    n_status = ST_INDEX;
                end else begin
                    n_cmd.op  = CELL_REMOVE;
                    n_cmd.tap = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            K_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (pos > cnt) begin
                    n_status = ST_INDEX;
                end else begin
                    n_cmd.op = CELL_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            K_POP, K_PEEK: begin
                if (r_count == '0) begin
                    n_status = ST_INDEX;
                end else begin
                    n_cmd.op     = CELL_READ;
                    n_cmd.tap    = 1'b1;
                    n_cmd.target = cnt - 1'b1;
                    if (i_req.kind == K_POP) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Next state: one pass through the row and the read-back tree.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CELL;
                end
            end
            S_CELL: n_state = S_GRP;
            S_GRP:  n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs; no request is taken while reset is asserted.
    always_comb begin
        i_req.ready  = 1'b0;
        o_rsp.valid  = 1'b0;
        case (r_state)
            S_IDLE:  i_req.ready = i_rst_n;
            S_OUT:   o_rsp.valid = 1'b1;
            default: i_req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cmd.op <= CELL_NOP;
            r_cmd.tap <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
                r_cmd   <= n_cmd;
            end else begin
                r_cmd.op  <= CELL_NOP;
                r_cmd.tap <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (r_state == S_SUM) begin
            r_data <= OUT_W'(i_sum);
        end
    end

    assign o_cmd        = r_cmd;
    assign o_rsp.status = r_status;
    assign o_rsp.data   = r_data;
    assign o_rsp.count  = COUNT_W'(r_count);

endmodule

FILE: tb/tb.sv
module tb;
    import ole_pkg::*;

    // Kinds outside the operation set; the block ignores them but still responds.
    localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int QUIET_TAIL    = 150;
    localparam int DRAIN_CYCLES  = 10;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_REPORTED  = 10;

    typedef enum {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } t_traffic_mode;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    data;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    // Shadow copy of the list that predicts every response in arrival order.
    class list_scoreboard;
        t_word        entries [CAPACITY];
        int           fill;
        t_list_result pending [$];
        int           mismatches;
        int           checked;
        int           full_hits;
        int           index_hits;
        int           peak_fill;

        function new();
            fill       = 0;
            mismatches = 0;
            checked    = 0;
            full_hits  = 0;
            index_hits = 0;
            peak_fill  = 0;
        endfunction

        // Applies one accepted request to the shadow list and queues its response.
        function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] value);
            t_list_result r;
            int           p;
            int           i;
            r.status = ST_OK;
            r.data   = '0;
            p        = int'(pos);
            case (t_kind'(kind))
                K_APPEND: begin
                    if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        entries[fill] = value[DATA_WIDTH-1:0];
                        fill++;
                    end
                end
                K_READ: begin
                    if (p >= fill) r.status = ST_INDEX;
                    else r.data = entries[p];
                end
                K_REMOVE: begin
                    if (p >= fill) begin
                        r.status = ST_INDEX;
                    end else begin
                        r.data = entries[p];
                        for (i = p; i + 1 < fill; i++) entries[i] = entries[i + 1];
                        fill--;
                    end
                end
                K_INSERT: begin
                    if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else if (p > fill) begin
                        r.status = ST_INDEX;
                    end else begin
                        for (i = fill; i > p; i--) entries[i] = entries[i - 1];
                        entries[p] = value[DATA_WIDTH-1:0];
                        fill++;
                    end
                end
                K_POP: begin
                    if (fill == 0) begin
                        r.status = ST_INDEX;
                    end else begin
                        fill--;
                        r.data = entries[fill];
                    end
                end
                K_PEEK: begin
                    if (fill == 0) r.status = ST_INDEX;
                    else r.data = entries[fill - 1];
                end
                default: ;
            endcase
            r.count = COUNT_W'(fill);
            if (r.status == ST_FULL) full_hits++;
            if (r.status == ST_INDEX) index_hits++;
            if (fill > peak_fill) peak_fill = fill;
            pending.push_back(r);
        endfunction

        function void log_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTED) $display("%0t: mismatch: %s", $time, what);
        endfunction

        // Compares one delivered response with the oldest outstanding prediction.
        function void check_response(logic [STATUS_W-1:0] status, logic [OUT_W-1:0] data,
                                     logic [COUNT_W-1:0] count);
            t_list_result e;
            checked++;
            if (pending.size() == 0) begin
                log_mismatch($sformatf("response with none outstanding: status %0d data %h count %0d",
                                       status, data, count));
                return;
            end
            e = pending.pop_front();
            if (status !== e.status || data !== e.data || count !== e.count) begin
                log_mismatch($sformatf("expected status %0d data %h count %0d, got %0d %h %0d",
                                       e.status, e.data, e.count, status, data, count));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_en;
    int   stall_left;
    int   quiet_cycles;
    int   sent;

    list_scoreboard sb;

    ole_req_if req_ch ();
    ole_rsp_if rsp_ch ();

    ordered_list_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Response stalls: short random bursts of ready low while idling is enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
        rsp_ch.ready <= (stall_left == 0);
    end

    // Every delivered response transaction is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.data, rsp_ch.count);
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request, with an optional idle burst first, and waits for acceptance.
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.position <= pos;
        req_ch.value    <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(kind, pos, value);
        sent++;
    endtask

    // Operation mix leans toward growth or shrinkage depending on the traffic mode.
    function automatic logic [KIND_W-1:0] pick_kind(t_traffic_mode mode);
        int r;
        if ($urandom_range(0, 99) < 3) return $urandom_range(0, 1) ? K_UNUSED_HI : K_UNUSED_LO;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 40) return K_APPEND;
                if (r < 70) return K_INSERT;
            end
            MODE_SHRINK: begin
                if (r < 35) return K_REMOVE;
                if (r < 65) return K_POP;
            end
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: return K_APPEND;
            1: return K_READ;
            2: return K_REMOVE;
            3: return K_INSERT;
            4: return K_POP;
            default: return K_PEEK;
        endcase
    endfunction

    // Indexes mostly fall inside the list, with some at or just past the end.
    function automatic logic [POS_W-1:0] pick_position(int fill);
        int r;
        int edge_pos;
        r        = $urandom_range(0, 9);
        edge_pos = (fill > CAPACITY - 1) ? CAPACITY - 1 : fill;
        if (r < 6) return POS_W'($urandom_range(0, (fill > 0) ? fill - 1 : 0));
        if (r == 6) return POS_W'(edge_pos);
        if (r == 7) return POS_W'((edge_pos + 1 > CAPACITY - 1) ? CAPACITY - 1 : edge_pos + 1);
        return POS_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, VALUE_W - 1);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_traffic_mode mode;
        int            seg_left;
        int            n;

        sb              = new();
        sent            = 0;
        stall_left      = 0;
        quiet_cycles    = 0;
        idle_en         = 1'b1;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: every access fails, insert past the end fails, unused kinds pass.
        issue_request(K_POP,       6'd0, '0);
        issue_request(K_PEEK,      6'd0, '0);
        issue_request(K_READ,      6'd0, '0);
        issue_request(K_REMOVE,    6'd0, '0);
        issue_request(K_INSERT,    6'd1, 32'h1234_5678);
        issue_request(K_UNUSED_LO, 6'd63, '1);
        issue_request(K_UNUSED_HI, 6'd0, '1);

        // Push to the front of an empty list, then build a short list.
        issue_request(K_INSERT, 6'd0, '1);
        issue_request(K_APPEND, 6'd0, '0);
        issue_request(K_APPEND, 6'd63, 32'hA5A5_5A5A);
        issue_request(K_INSERT, 6'd3, 32'h8000_0001);
        issue_request(K_INSERT, 6'd0, 32'h0000_0001);
        issue_request(K_INSERT, 6'd2, 32'h7FFF_FFFE);

        // Reads at both ends, at the count and at the top index.
        issue_request(K_READ, 6'd0, '0);
        issue_request(K_READ, 6'd5, '0);
        issue_request(K_READ, 6'd6, '0);
        issue_request(K_READ, 6'd63, '0);

        // Removal from the middle, removal at the count, then the tail operations.
        issue_request(K_REMOVE, 6'd2, '0);
        issue_request(K_REMOVE, 6'd5, '0);
        issue_request(K_PEEK,   6'd0, '0);
        issue_request(K_POP,    6'd0, '0);
        issue_request(K_REMOVE, 6'd0, '0);

        // Random traffic in segments that fill, drain or churn the list.
        mode     = MODE_GROW;
        seg_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 160);
                if (sb.fill < 8) mode = ($urandom_range(0, 3) != 0) ? MODE_GROW : MODE_MIXED;
                else if (sb.fill == CAPACITY) mode = ($urandom_range(0, 2) != 0) ? MODE_SHRINK
                                                                                : MODE_GROW;
                else mode = t_traffic_mode'($urandom_range(0, 2));
            end
            seg_left--;
            if (n == RANDOM_ITEMS - QUIET_TAIL) idle_en = 1'b0;
            begin
                logic [KIND_W-1:0] kind;
                kind = pick_kind(mode);
                issue_request(kind, pick_position(sb.fill), pick_word());
            end
        end
        req_ch.valid <= 1'b0;

        // Drain the outstanding responses, then watch for strays.
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d list requests, checked %0d responses, %0d mismatches.",
                 sent, sb.checked, sb.mismatches);
        $display("List reached %0d entries; %0d full and %0d index errors were exercised.",
                 sb.peak_fill, sb.full_hits, sb.index_hits);
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ole_pkg.sv
hw/rtl/ole_if.sv
hw/rtl/ole_cell.sv
hw/rtl/ole_or_tree.sv
hw/rtl/ole_ctrl.sv
hw/rtl/ordered_list_engine_unit.sv
tb/tb.sv
